// File: rtl/core/chfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfi_pkg
// Shared constants and types of the chained hash find-or-insert block.
// ----------------------------------------------------------------------------
package chfi_pkg;

   localparam int unsigned PrimaryBuckets = 4096;
   localparam int unsigned Capacity       = 1024;
   localparam int unsigned KeyWidth       = 64;
   localparam int unsigned ValueWidth     = 16;
   localparam int unsigned CountWidth     = 11;
   localparam int unsigned BucketWidth    = 12;
   localparam int unsigned BucketShift    = 4;
   localparam int unsigned QueueDepth     = 2;

   typedef struct packed {
      logic [KeyWidth-1:0]   key;
      logic [ValueWidth-1:0] payload;
   } item_type;

   typedef struct packed {
      logic [ValueWidth-1:0] result_value;
      logic                  found;
      logic                  full_res;
      logic [CountWidth-1:0] entry_count;
   } result_type;

endpackage

// File: rtl/core/chfi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfi_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module chfi_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/chfi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfi_queue
// Short item queue between the front end and the chain walker.
// ----------------------------------------------------------------------------
module chfi_queue #(
   parameter int unsigned Depth = chfi_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  chfi_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output chfi_pkg::item_type out_item
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;

   chfi_pkg::item_type    slots_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]     count_ff, count_in;
   logic                  push, pop;

   assign in_ready  = (count_ff != PtrWidth'(0) + (PtrWidth+1)'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_item  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/core/chfi_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chfi_walker
// Walks one bucket chain per item, appends on a miss if there is room and drives
// the result register. Also runs the bucket-length clearing pass after reset.
// ----------------------------------------------------------------------------
module chfi_walker #(
   parameter int unsigned PrimaryBuckets = chfi_pkg::PrimaryBuckets,
   parameter int unsigned Capacity       = chfi_pkg::Capacity
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  chfi_pkg::item_type   item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output chfi_pkg::result_type rsp,
   output logic                 busy_clear
);

   localparam int unsigned SlotCount = PrimaryBuckets + Capacity;
   localparam int unsigned SlotWidth = $clog2(SlotCount);
   localparam int unsigned BktWidth  = $clog2(PrimaryBuckets);
   localparam int unsigned EntWidth  = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int unsigned CntWidth  = $clog2(Capacity + 1);
   localparam int unsigned LenWidth  = chfi_pkg::CountWidth;
   localparam int unsigned KeyW      = chfi_pkg::KeyWidth;
   localparam int unsigned ValW      = chfi_pkg::ValueWidth;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LEN, ST_SLOT, ST_ENTRY, ST_CMP, ST_OUT
   } state_type;

   state_type              state_ff;
   chfi_pkg::item_type     item_ff;
   logic [BktWidth-1:0]    clr_ff;
   logic [SlotWidth-1:0]   slot_ff;
   logic [LenWidth-1:0]    len_ff, idx_ff;
   logic [CntWidth-1:0]    count_ff;
   logic [SlotWidth:0]     next_slot_ff;
   chfi_pkg::result_type   rsp_ff;
   logic                   rsp_valid_ff;

   logic                   len_we, slot_we, ent_we;
   logic [BktWidth-1:0]    len_wa, len_ra;
   logic [LenWidth-1:0]    len_wd, len_rd;
   logic [SlotWidth-1:0]   slot_wa, slot_ra, link_rd;
   logic [EntWidth-1:0]    sidx_rd, ent_ra, ent_wa;
   logic                   link_we;
   logic [SlotWidth-1:0]   link_wa;
   logic [KeyW-1:0]        key_rd;
   logic [ValW-1:0]        val_rd;
   logic [BktWidth-1:0]    bucket;
   logic                   full_now;

   assign bucket   = item_ff.key[chfi_pkg::BucketShift +: BktWidth];
   assign full_now = (count_ff >= CntWidth'(Capacity));
   assign ent_wa   = count_ff[EntWidth-1:0];

   // The bucket length is read as the item is taken, so it is ready in ST_LEN.
   assign len_ra = (state_ff == ST_IDLE) ? item.key[chfi_pkg::BucketShift +: BktWidth]
                                         : bucket;

   chfi_ram #(.Width(LenWidth), .Depth(PrimaryBuckets)) u_len (
      .clock, .wr_en(len_we), .wr_addr(len_wa), .wr_data(len_wd),
      .rd_addr(len_ra), .rd_data(len_rd));
   chfi_ram #(.Width(EntWidth), .Depth(SlotCount)) u_sidx (
      .clock, .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(ent_wa),
      .rd_addr(slot_ra), .rd_data(sidx_rd));
   chfi_ram #(.Width(SlotWidth), .Depth(SlotCount)) u_link (
      .clock, .wr_en(link_we), .wr_addr(link_wa),
      .wr_data(next_slot_ff[SlotWidth-1:0]), .rd_addr(slot_ra), .rd_data(link_rd));
   chfi_ram #(.Width(KeyW), .Depth(Capacity)) u_key (
      .clock, .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(item_ff.key),
      .rd_addr(ent_ra), .rd_data(key_rd));
   chfi_ram #(.Width(ValW), .Depth(Capacity)) u_val (
      .clock, .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(item_ff.payload),
      .rd_addr(ent_ra), .rd_data(val_rd));

   assign slot_ra    = slot_ff;
   assign ent_ra     = sidx_rd;
   assign item_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;
   assign busy_clear = (state_ff == ST_CLEAR);

   logic hit, last, insert_ok;
   assign hit  = (key_rd == item_ff.key);
   assign last = (idx_ff + 1'b1 == len_ff);
   assign insert_ok = !full_now && (next_slot_ff < (SlotWidth+1)'(SlotCount));

   always_comb begin
      len_we  = 1'b0;
      len_wa  = bucket;
      len_wd  = '0;
      slot_we = 1'b0;
      slot_wa = slot_ff;
      link_we = 1'b0;
      link_wa = slot_ff;
      ent_we  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            len_we = 1'b1;
            len_wa = clr_ff;
         end
         ST_LEN: begin
            if (len_rd == '0 && !full_now) begin
               len_we  = 1'b1;
               len_wd  = LenWidth'(1);
               slot_we = 1'b1;
               slot_wa = SlotWidth'(bucket);
               ent_we  = 1'b1;
            end
         end
         ST_CMP: begin
            if (!hit && last && insert_ok) begin
               len_we  = 1'b1;
               len_wd  = len_ff + 1'b1;
               slot_we = 1'b1;
               slot_wa = next_slot_ff[SlotWidth-1:0];
               link_we = 1'b1;
               ent_we  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         next_slot_ff <= (SlotWidth+1)'(PrimaryBuckets);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BktWidth'(PrimaryBuckets - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (item_valid && !rsp_valid_ff) begin
                  item_ff  <= item;
                  state_ff <= ST_LEN;
               end
            end
            ST_LEN: begin
               len_ff  <= len_rd;
               idx_ff  <= '0;
               slot_ff <= SlotWidth'(bucket);
               rsp_ff.result_value <= item_ff.payload;
               rsp_ff.found        <= 1'b0;
               rsp_ff.full_res     <= (len_rd == '0) && full_now;
               if (len_rd == '0) begin
                  if (full_now) begin
                     rsp_ff.entry_count <= LenWidth'(count_ff);
                  end else begin
                     count_ff <= count_ff + 1'b1;
                     rsp_ff.entry_count <= LenWidth'(count_ff + 1'b1);
                  end
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_SLOT;
               end
            end
            ST_SLOT: begin
               state_ff <= ST_ENTRY;
            end
            ST_ENTRY: begin
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (hit) begin
                  rsp_ff.result_value <= val_rd;
                  rsp_ff.found        <= 1'b1;
                  rsp_ff.entry_count  <= LenWidth'(count_ff);
                  state_ff <= ST_OUT;
               end else if (last) begin
                  if (insert_ok) begin
                     count_ff     <= count_ff + 1'b1;
                     next_slot_ff <= next_slot_ff + 1'b1;
                     rsp_ff.entry_count <= LenWidth'(count_ff + 1'b1);
                  end else begin
                     rsp_ff.full_res    <= 1'b1;
                     rsp_ff.entry_count <= LenWidth'(count_ff);
                  end
                  state_ff <= ST_OUT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  slot_ff  <= link_rd;
                  state_ff <= ST_SLOT;
               end
            end
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/chained_hash_find_or_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_find_or_insert
// Find-or-insert into a separately chained hash map of 64-bit keys.
// ----------------------------------------------------------------------------
// Usage:
//   Items (req_key, req_payload) enter through a valid/ready channel into a
//   two-item queue, so the sender is released while the walker works.
//   Bits 4 to 15 of the key pick a bucket; the walker reads the bucket
//   length as it takes the item, then follows the chain, visiting each slot
//   in the states ST_SLOT, ST_ENTRY and ST_CMP through the registered slot
//   and key memories. The walker takes a new item only once it has finished
//   the last one and the receiver has taken its result.
//   Results (rsp_result_value, rsp_found, rsp_full_res, rsp_entry_count)
//   are held in an output register until taken; while the receiver stalls
//   the walker waits, and the queue keeps accepting until it is full.
//   After reset a clearing pass zeros the 4096 bucket lengths; no item is
//   accepted during it.
// ----------------------------------------------------------------------------
module chained_hash_find_or_insert #(
   parameter int unsigned Capacity = chfi_pkg::Capacity
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [chfi_pkg::KeyWidth-1:0]       req_key,
   input  logic [chfi_pkg::ValueWidth-1:0]     req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [chfi_pkg::ValueWidth-1:0]     rsp_result_value,
   output logic                                rsp_found,
   output logic                                rsp_full_res,
   output logic [chfi_pkg::CountWidth-1:0]     rsp_entry_count
);

   chfi_pkg::item_type   in_item, q_item;
   chfi_pkg::result_type rsp;
   logic                 q_valid, q_ready, q_in_ready, busy_clear;

   assign in_item.key     = req_key;
   assign in_item.payload = req_payload;
   assign req_ready       = q_in_ready && !busy_clear;

   chfi_queue #(.Depth(chfi_pkg::QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(req_valid && !busy_clear), .in_ready(q_in_ready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

   chfi_walker #(.PrimaryBuckets(chfi_pkg::PrimaryBuckets), .Capacity(Capacity)) u_walker (
      .clock, .reset,
      .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
      .rsp_valid, .rsp_ready, .rsp, .busy_clear);

   assign rsp_result_value = rsp.result_value;
   assign rsp_found        = rsp.found;
   assign rsp_full_res     = rsp.full_res;
   assign rsp_entry_count  = rsp.entry_count;

`ifndef NO_ASSERTIONS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      busy_clear |-> !req_ready) else $error("item accepted during clearing pass");
   a_found_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_full_res)) else $error("found and full together");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= chfi_pkg::CountWidth'(Capacity))
      else $error("entry count beyond capacity");
`endif

endmodule

// File: tb/chained_hash_find_or_insert_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_find_or_insert_test
// Drives find-or-insert items with random sender gaps and receiver stalls,
// predicts each result with a behavioural hash map and checks it.
// ----------------------------------------------------------------------------
module chained_hash_find_or_insert_test;

   localparam int unsigned SlotCount = chfi_pkg::PrimaryBuckets + chfi_pkg::Capacity;
   localparam int unsigned IdleLimit = 20000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [chfi_pkg::KeyWidth-1:0]   req_key = '0;
   logic [chfi_pkg::ValueWidth-1:0] req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [chfi_pkg::ValueWidth-1:0] rsp_result_value;
   logic                            rsp_found;
   logic                            rsp_full_res;
   logic [chfi_pkg::CountWidth-1:0] rsp_entry_count;

   chained_hash_find_or_insert uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_key(req_key), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_found(rsp_found),
      .rsp_full_res(rsp_full_res), .rsp_entry_count(rsp_entry_count)
   );

   always #5 clock = ~clock;

   // Behavioural copy of the map.
   int unsigned                     chain_length [chfi_pkg::PrimaryBuckets];
   logic [chfi_pkg::KeyWidth-1:0]   stored_keys [chfi_pkg::Capacity];
   logic [chfi_pkg::ValueWidth-1:0] stored_values [chfi_pkg::Capacity];
   int unsigned                     slot_entry [SlotCount];
   int unsigned                     slot_link [SlotCount];
   int unsigned                     key_total;
   int unsigned                     spare_slot;

   chfi_pkg::item_type            pending_items [$];
   chfi_pkg::result_type          awaited_results [$];
   logic [chfi_pkg::KeyWidth-1:0] known_keys [$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   bit  hold_sender = 1'b0;
   bit  req_taken = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;

   function automatic chfi_pkg::result_type find_or_insert(chfi_pkg::item_type it);
      chfi_pkg::result_type r;
      int unsigned bucket;
      int unsigned len;
      int unsigned slot;
      int unsigned fresh;
      bit          hit;
      bucket = 32'((it.key >> chfi_pkg::BucketShift)
                   & 64'(chfi_pkg::PrimaryBuckets - 1));
      len = chain_length[bucket];
      r.result_value = it.payload;
      r.found = 1'b0;
      r.full_res = 1'b0;
      hit = 1'b0;
      slot = bucket;
      for (int unsigned i = 0; i < len && !hit; i++) begin
         if (stored_keys[slot_entry[slot]] == it.key) begin
            r.result_value = stored_values[slot_entry[slot]];
            hit = 1'b1;
         end else if (i + 1 < len) begin
            slot = slot_link[slot];
         end
      end
      if (hit) begin
         r.found = 1'b1;
      end else if (key_total >= chfi_pkg::Capacity
                   || (len != 0 && spare_slot >= SlotCount)) begin
         r.full_res = 1'b1;
      end else begin
         if (len == 0) begin
            fresh = bucket;
         end else begin
            fresh = spare_slot;
            spare_slot++;
            slot_link[slot] = fresh;
         end
         slot_entry[fresh] = key_total;
         stored_keys[key_total] = it.key;
         stored_values[key_total] = it.payload;
         key_total++;
         chain_length[bucket] = (len + 1) & 11'h7ff;
      end
      r.entry_count = key_total[chfi_pkg::CountWidth-1:0];
      return r;
   endfunction

   function automatic logic [chfi_pkg::KeyWidth-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Keys with a chosen bucket, so that chains grow long.
   function automatic logic [chfi_pkg::KeyWidth-1:0] key_in_bucket(int unsigned bucket);
      logic [chfi_pkg::KeyWidth-1:0] k;
      k = random_key();
      k[15:4] = bucket[11:0];
      return k;
   endfunction

   function automatic logic [chfi_pkg::ValueWidth-1:0] random_value();
      return chfi_pkg::ValueWidth'($urandom);
   endfunction

   task automatic queue_item(logic [chfi_pkg::KeyWidth-1:0] k,
                             logic [chfi_pkg::ValueWidth-1:0] v);
      chfi_pkg::item_type it;
      it.key = k;
      it.payload = v;
      pending_items.push_back(it);
      known_keys.push_back(k);
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
      end
   end

   // Records accepted items at the rising edge for the driver and the predictor.
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            awaited_results.push_back(find_or_insert({req_key, req_payload}));
         end
      end
   end

   // Driver, operating on the falling edge after accepts were recorded.
   always @(negedge clock) begin
      chfi_pkg::item_type it;
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_items.size() != 0 && !hold_sender) begin
            it = pending_items.pop_front();
            req_valid <= 1'b1;
            req_key <= it.key;
            req_payload <= it.payload;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      chfi_pkg::result_type exp;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Result item with no expectation: value %h found %b full %b count %0d",
                     rsp_result_value, rsp_found, rsp_full_res, rsp_entry_count);
               end
            end else begin
               exp = awaited_results.pop_front();
               if (rsp_result_value !== exp.result_value || rsp_found !== exp.found
                     || rsp_full_res !== exp.full_res
                     || rsp_entry_count !== exp.entry_count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"Mismatch: expected value %h found %b full %b count %0d,",
                               " got value %h found %b full %b count %0d"},
                        exp.result_value, exp.found, exp.full_res, exp.entry_count,
                        rsp_result_value, rsp_found, rsp_full_res, rsp_entry_count);
                  end
               end
            end
         end
         if (idle_cycles >= IdleLimit) begin
            $display("chained_hash_find_or_insert_test: errors");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < chfi_pkg::PrimaryBuckets; i++) begin
         chain_length[i] = 0;
      end
      key_total = 0;
      spare_slot = chfi_pkg::PrimaryBuckets;

      // Directed part: key extremes, an empty bucket, chain growth, repeats.
      queue_item('0, 16'h0000);
      queue_item('1, 16'hffff);
      queue_item('0, 16'h1234);
      queue_item('1, 16'h5678);
      queue_item(64'h0000_0000_0000_000f, 16'haaaa);
      queue_item(64'h8000_0000_0000_0000, 16'h5555);
      queue_item(64'h0000_0000_0000_fff0, 16'h0001);
      queue_item(64'hffff_ffff_ffff_000f, 16'h8000);
      queue_item(64'h8000_0000_0000_0000, 16'h0000);
      queue_item(64'h0000_0000_0000_000f, 16'hffff);
      for (int i = 0; i < 6; i++) begin
         queue_item(key_in_bucket(12'h123), random_value());
      end
      for (int i = 0; i < 6; i++) begin
         queue_item(known_keys[known_keys.size() - 6], random_value());
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Random part in phases; the store is then filled until it is full.
      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < 140; i++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: queue_item(known_keys[$urandom_range(0, known_keys.size() - 1)],
                                   random_value());
               3, 4: queue_item(key_in_bucket($urandom_range(0, 15)), random_value());
               5: queue_item(($urandom_range(0, 1) != 0) ? '1 : '0, random_value());
               default: queue_item(random_key(), random_value());
            endcase
         end
         wait (pending_items.size() == 0);
         if (phase == 1) begin
            hold_sender = 1'b1;
            wait (awaited_results.size() == 0 && !req_valid);
            hold_sender = 1'b0;
         end
      end
      while (key_total < chfi_pkg::Capacity + 40) begin
         queue_item(random_key(), random_value());
         wait (pending_items.size() == 0);
         @(posedge clock);
         if (key_total >= chfi_pkg::Capacity && pending_items.size() == 0) begin
            for (int i = 0; i < 40; i++) begin
               queue_item(($urandom_range(0, 1) != 0) ? random_key()
                  : known_keys[$urandom_range(0, known_keys.size() - 1)], random_value());
            end
            break;
         end
      end
      wait (pending_items.size() == 0);
      wait (!req_valid);
      wait (awaited_results.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("chained_hash_find_or_insert_test: clean");
      end else begin
         $display("chained_hash_find_or_insert_test: errors");
      end
      $finish;
   end

endmodule
